@@ hw/rtl/lew_pkg.sv @@
`timescale 1ns / 1ps
package lew_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd3;

  // item kinds on in_tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [PIX_W-1:0] GAIN_RST         = 8'd255;
  localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX          = 8'hFF;

  // luma = (30R + 59G + 11B) / 100, divide done as multiply by 2^19/100 rounded up
  localparam int LUMA_COEF_R = 30;
  localparam int LUMA_COEF_G = 59;
  localparam int LUMA_COEF_B = 11;
  localparam int LUMA_SUM_W  = 15;
  localparam int LUMA_RECIP  = 5243;
  localparam int LUMA_RCP_W  = 13;
  localparam int LUMA_SHIFT  = 19;
  localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RCP_W;

  localparam int NUM_CELLS   = 3;
  localparam int CENTRE_CELL = 1;
  localparam int NSUM_W      = 10;
  localparam int EMAG_W      = 11;
  localparam int EDGE_W      = EMAG_W + 1;
  localparam int PE_W        = EMAG_W + PIX_W;
  localparam int PL_W        = 2 * PIX_W;

  // 255 * 255: any product at or above this scales to 255 or more
  localparam logic [PE_W-1:0] SAT_PROD = 19'd65025;

  typedef struct packed {
    logic [PIX_W-1:0] bot;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
  } col_t;

  typedef struct packed {
    logic col;
    logic top;
    logic mid;
    logic bot;
  } cell_en_t;

  typedef struct packed {
    logic ox_nz;
    logic ox_last;
    logic oy_nz;
    logic oy_last;
  } pos_t;

  typedef struct packed {
    logic ox_nz;
    logic last;
  } out_tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] above;
  } line_t;

  function automatic logic [LUMA_SUM_W-1:0] luma_sum(input logic [PIX_W-1:0] r,
                                                     input logic [PIX_W-1:0] g,
                                                     input logic [PIX_W-1:0] b);
    logic [LUMA_SUM_W-1:0] s;
    s = LUMA_SUM_W'(r) * LUMA_SUM_W'(LUMA_COEF_R)
      + LUMA_SUM_W'(g) * LUMA_SUM_W'(LUMA_COEF_G)
      + LUMA_SUM_W'(b) * LUMA_SUM_W'(LUMA_COEF_B);
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] luma_div100(input logic [LUMA_SUM_W-1:0] s);
    logic [LUMA_PROD_W-1:0] p;
    p = LUMA_PROD_W'(s) * LUMA_PROD_W'(LUMA_RECIP);
    return p[LUMA_SHIFT +: PIX_W];
  endfunction

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [PIX_W-1:0] div255(input logic [PL_W-1:0] x);
    logic [PL_W:0] t;
    t = (PL_W+1)'(x) + (PL_W+1)'(x[PL_W-1:PIX_W]) + (PL_W+1)'(1);
    return t[PL_W-1:PIX_W];
  endfunction

endpackage

@@ hw/rtl/lew_line_buf.sv @@
`timescale 1ns / 1ps
module lew_line_buf #(
  parameter int DEPTH = lew_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output lew_pkg::line_t           rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  lew_pkg::line_t           wr_data
);

  lew_pkg::line_t mem [DEPTH];
  lew_pkg::line_t q_r;
  lew_pkg::line_t byp_r;
  logic           byp_sel_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r   <= mem[rd_addr];
      byp_r <= wr_data;
    end
  end

  // read and write of the same column in one cycle: return the new entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_sel_r <= 1'b0;
    end else if (rd_en) begin
      byp_sel_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_sel_r ? byp_r : q_r;

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
    else $error("line store read did not see same-cycle write");

endmodule

@@ hw/rtl/lew_cell.sv @@
`timescale 1ns / 1ps
module lew_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  lew_pkg::col_t                col_in,
  input  lew_pkg::cell_en_t            en,
  output lew_pkg::col_t                col_q,
  output logic [lew_pkg::NSUM_W-1:0]   nb_sum
);

  lew_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_q = col_r;

  // neighbor contribution of this window column, out-of-frame taps and the window centre masked
  always_comb begin
    nb_sum = '0;
    if (en.col) begin
      nb_sum = (en.top ? lew_pkg::NSUM_W'(col_r.top) : '0)
             + (en.mid ? lew_pkg::NSUM_W'(col_r.mid) : '0)
             + (en.bot ? lew_pkg::NSUM_W'(col_r.bot) : '0);
    end
  end

endmodule

@@ hw/rtl/lew_scale_out.sv @@
`timescale 1ns / 1ps
module lew_scale_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [lew_pkg::EMAG_W-1:0]    s_edge,
  input  logic [lew_pkg::PIX_W-1:0]     s_luma,
  input  lew_pkg::out_tag_t             s_tag,
  input  logic [lew_pkg::PIX_W-1:0]     gain,
  input  logic [lew_pkg::PIX_W-1:0]     threshold,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [4*lew_pkg::PIX_W-1:0]   m_data,
  output logic                          m_last
);

  logic                          v3_r, v4_r, ov_r;
  logic                          ready3, ready4, ready_o;
  logic [lew_pkg::EMAG_W-1:0]    e3_r;
  logic [lew_pkg::PIX_W-1:0]     l3_r;
  lew_pkg::out_tag_t             t3_r, t4_r;
  logic [lew_pkg::PE_W-1:0]      pe4_r;
  logic [lew_pkg::PL_W-1:0]      pl4_r;
  logic [lew_pkg::PIX_W-1:0]     se, sl, rg;
  logic [lew_pkg::PIX_W-1:0]     rg_r, sl_r;
  logic                          last_r;

  assign ready_o = !ov_r || m_ready;
  assign ready4  = !v4_r || ready_o;
  assign ready3  = !v3_r || ready4;
  assign s_ready = ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ready3) begin
        v3_r <= s_valid;
      end
      if (ready4) begin
        v4_r <= v3_r;
      end
      if (ready_o) begin
        ov_r <= v4_r;
      end
    end
  end

  always_comb begin
    se = (pe4_r >= lew_pkg::SAT_PROD) ? lew_pkg::PIX_MAX
                                      : lew_pkg::div255(pe4_r[lew_pkg::PL_W-1:0]);
    sl = lew_pkg::div255(pl4_r);
    rg = (se > threshold && t4_r.ox_nz) ? lew_pkg::PIX_MAX : sl;
  end

  always_ff @(posedge clk) begin
    if (ready3 && s_valid) begin
      e3_r <= s_edge;
      l3_r <= s_luma;
      t3_r <= s_tag;
    end
    if (ready4 && v3_r) begin
      pe4_r <= lew_pkg::PE_W'(e3_r) * lew_pkg::PE_W'(gain);
      pl4_r <= lew_pkg::PL_W'(l3_r) * lew_pkg::PL_W'(gain);
      t4_r  <= t3_r;
    end
    if (ready_o && v4_r) begin
      rg_r   <= rg;
      sl_r   <= sl;
      last_r <= t4_r.last;
    end
  end

  assign m_valid = ov_r;
  assign m_data  = {lew_pkg::PIX_MAX, sl_r, rg_r, rg_r};
  assign m_last  = last_r;

endmodule

@@ hw/rtl/laplacian_edge_overlay.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// in_      in   tvalid / tready    tdata {blue, green, red}, tuser func
// out_     out  tvalid / tready    tdata {alpha, blue, green, red}, tlast frame_end
// cfg_     in   valid / ready      index, data (cfg_ready is always high)
//
// One item per clock sustained while the output is not stalled.
// Path: position counters, line store read, 3-cell window, scale multiply, output register.
// Line store is one single-port-write memory read once per item; the window is the
// stage register for the Laplacian, so a stalled result holds the window in place.
// Reset clears counters, valids, config registers and the line store bypass select only;
// line stores are not cleared, every value used was written earlier in the same frame.
// Bubbles collapse: a stalled output still lets items enter until the pipeline is full.
module laplacian_edge_overlay #(
  parameter int MAX_WIDTH  = lew_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lew_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [3*lew_pkg::PIX_W-1:0]       in_tdata,  // red, green, blue
  input  logic                              in_tuser,  // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [4*lew_pkg::PIX_W-1:0]       out_tdata, // out_red, out_green, out_blue, out_alpha
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lew_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lew_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

  localparam int PW = lew_pkg::PIX_W;

  // configuration
  logic [lew_pkg::DIM_W-1:0] frame_width_r, frame_height_r;
  logic [PW-1:0]             gain_r, threshold_r;
  logic                      cfg_fire, cfg_restart;
  logic [CNT_W-1:0]          w_used;
  logic [HCNT_W-1:0]         h_used;

  // stream position
  logic [COL_W-1:0]  in_col_r, in_col_nxt, col_eff;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, row_eff;
  logic [COL_W-1:0]  ocol_r, ocol_nxt, ocol_eff;
  logic [OROW_W-1:0] orow_r, orow_nxt, orow_eff;
  logic              is_drain, draining, restart_in, take, emit, col_wrap, last;
  lew_pkg::pos_t     pos0;
  logic [PW-1:0]     red0, green0, blue0;

  // stage 1: line store data
  logic                          v1_r, s1_go, ready2;
  logic [COL_W-1:0]              s1_col_r;
  logic [PW-1:0]                 s1_red_r;
  logic [lew_pkg::LUMA_SUM_W-1:0] s1_sum_r;
  logic                          s1_emit_r;
  lew_pkg::pos_t                 s1_pos_r;
  lew_pkg::line_t                rd_line, wr_line;
  lew_pkg::col_t                 new_col;
  logic [PW-1:0]                 luma_dly_r;

  // stage 2: window
  logic                          v2_r, sc_ready;
  lew_pkg::pos_t                 pos2_r;
  logic [PW-1:0]                 lum2_r;
  lew_pkg::col_t                 cell_col [lew_pkg::NUM_CELLS];
  logic [lew_pkg::NSUM_W-1:0]    cell_sum [lew_pkg::NUM_CELLS];
  logic [lew_pkg::EMAG_W-1:0]    nb_total, edge_pos;
  logic signed [lew_pkg::EDGE_W-1:0] edge_val;
  lew_pkg::out_tag_t             tag2;

  // ---------------- configuration ----------------
  assign cfg_ready   = 1'b1;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_fire && (cfg_index == lew_pkg::REG_FRAME_WIDTH ||
                                    cfg_index == lew_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lew_pkg::FRAME_WIDTH_RST;
      frame_height_r <= lew_pkg::FRAME_HEIGHT_RST;
      gain_r         <= lew_pkg::GAIN_RST;
      threshold_r    <= lew_pkg::THRESHOLD_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        lew_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        lew_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        lew_pkg::REG_GAIN:         gain_r         <= cfg_data[PW-1:0];
        lew_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[PW-1:0];
      endcase
    end
  end

  always_comb begin
    priority if (frame_width_r == '0) begin
      w_used = CNT_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_used = CNT_W'(MAX_WIDTH);
    end else begin
      w_used = CNT_W'(frame_width_r);
    end
    priority if (frame_height_r == '0) begin
      h_used = HCNT_W'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_used = HCNT_W'(MAX_HEIGHT);
    end else begin
      h_used = HCNT_W'(frame_height_r);
    end
  end

  // ---------------- stage 0: position ----------------
  assign in_tready  = !v1_r || ready2;
  assign is_drain   = (in_tuser == lew_pkg::FUNC_DRAIN);
  assign draining   = in_row_r >= ROW_W'(h_used);
  // drain tick before the frame is complete has no effect
  assign take       = in_tvalid && in_tready && !(is_drain && !draining);
  // pixel during drain drops the old frame's tail
  assign restart_in = !is_drain && draining;

  always_comb begin
    col_eff  = restart_in ? '0 : in_col_r;
    row_eff  = restart_in ? '0 : in_row_r;
    ocol_eff = restart_in ? '0 : ocol_r;
    orow_eff = restart_in ? '0 : orow_r;

    emit     = (row_eff >= ROW_W'(2)) || (row_eff == ROW_W'(1) && col_eff != '0);
    col_wrap = (CNT_W'(col_eff) + CNT_W'(1)) >= w_used;

    pos0.ox_nz   = (ocol_eff != '0);
    pos0.ox_last = (CNT_W'(ocol_eff) + CNT_W'(1)) >= w_used;
    pos0.oy_nz   = (orow_eff != '0);
    pos0.oy_last = (HCNT_W'(orow_eff) + HCNT_W'(1)) >= h_used;
    last         = emit && pos0.ox_last && pos0.oy_last;

    red0   = is_drain ? '0 : in_tdata[0 +: PW];
    green0 = is_drain ? '0 : in_tdata[PW +: PW];
    blue0  = is_drain ? '0 : in_tdata[2*PW +: PW];

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    if (take) begin
      in_col_nxt = col_wrap ? '0 : col_eff + COL_W'(1);
      in_row_nxt = col_wrap ? row_eff + ROW_W'(1) : row_eff;
      ocol_nxt   = ocol_eff;
      orow_nxt   = orow_eff;
      if (emit) begin
        ocol_nxt = pos0.ox_last ? '0 : ocol_eff + COL_W'(1);
        orow_nxt = pos0.ox_last ? orow_eff + OROW_W'(1) : orow_eff;
      end
      if (last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
      end
    end
    if (cfg_restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      ocol_nxt   = '0;
      orow_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
    end
  end

  // ---------------- stage 1: line store ----------------
  assign s1_go = v1_r && ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (take) begin
      v1_r <= 1'b1;
    end else if (s1_go) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col_r  <= col_eff;
      s1_red_r  <= red0;
      s1_sum_r  <= lew_pkg::luma_sum(red0, green0, blue0);
      s1_emit_r <= emit;
      s1_pos_r  <= pos0;
    end
  end

  always_comb begin
    wr_line.luma   = lew_pkg::luma_div100(s1_sum_r);
    wr_line.centre = s1_red_r;
    wr_line.above  = rd_line.centre;
    new_col.top    = rd_line.above;
    new_col.mid    = rd_line.centre;
    new_col.bot    = s1_red_r;
  end

  lew_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (take),
    .rd_addr (col_eff),
    .rd_data (rd_line),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (wr_line)
  );

  // ---------------- stage 2: window cells ----------------
  assign ready2 = !v2_r || sc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s1_go) begin
      v2_r <= s1_emit_r;
    end else if (sc_ready) begin
      v2_r <= 1'b0;
    end
  end

  // luma of the previous row is held one item so it lines up with the window centre
  always_ff @(posedge clk) begin
    if (s1_go) begin
      luma_dly_r <= rd_line.luma;
      lum2_r     <= luma_dly_r;
      pos2_r     <= s1_pos_r;
    end
  end

  for (genvar i = 0; i < lew_pkg::NUM_CELLS; i++) begin : g_cell
    lew_pkg::cell_en_t en;
    lew_pkg::col_t     col_in;

    assign en.col = (i == 0) ? pos2_r.ox_nz :
                    ((i == lew_pkg::NUM_CELLS - 1) ? !pos2_r.ox_last : 1'b1);
    assign en.top = pos2_r.oy_nz;
    assign en.mid = (i != lew_pkg::CENTRE_CELL);
    assign en.bot = !pos2_r.oy_last;

    if (i == lew_pkg::NUM_CELLS - 1) begin : g_feed
      assign col_in = new_col;
    end else begin : g_link
      assign col_in = cell_col[i+1];
    end

    lew_cell u_cell (
      .clk      (clk),
      .shift_en (s1_go),
      .col_in   (col_in),
      .en       (en),
      .col_q    (cell_col[i]),
      .nb_sum   (cell_sum[i])
    );
  end

  always_comb begin
    nb_total = lew_pkg::EMAG_W'(cell_sum[0]) + lew_pkg::EMAG_W'(cell_sum[1])
             + lew_pkg::EMAG_W'(cell_sum[2]);
    edge_val = $signed({1'b0, cell_col[lew_pkg::CENTRE_CELL].mid, 3'b000})
             - $signed({1'b0, nb_total});
    edge_pos = (!edge_val[lew_pkg::EDGE_W-1] && edge_val != '0)
             ? edge_val[lew_pkg::EMAG_W-1:0] : '0;
    tag2.ox_nz = pos2_r.ox_nz;
    tag2.last  = pos2_r.ox_last && pos2_r.oy_last;
  end

  // ---------------- stages 3, 4 and output ----------------
  lew_scale_out u_scale_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (v2_r),
    .s_ready   (sc_ready),
    .s_edge    (edge_pos),
    .s_luma    (lum2_r),
    .s_tag     (tag2),
    .gain      (gain_r),
    .threshold (threshold_r),
    .m_valid   (out_tvalid),
    .m_ready   (out_tready),
    .m_data    (out_tdata),
    .m_last    (out_tlast)
  );

  a_cols_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(in_col_r) < w_used && CNT_W'(ocol_r) < w_used)
    else $error("column counter outside frame width");

  a_rows_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= ROW_W'(h_used) + ROW_W'(1) && HCNT_W'(orow_r) < h_used)
    else $error("row counter outside frame and drain rows");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> in_col_r == '0 && in_row_r == '0 && ocol_r == '0 && orow_r == '0)
    else $error("stream did not restart after last item of frame");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int PIX_W      = lew_pkg::PIX_W;
  localparam int DIM_W      = lew_pkg::DIM_W;
  localparam int CFG_IDX_W  = lew_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lew_pkg::CFG_DATA_W;

  localparam int LINE_DEPTH    = lew_pkg::MAX_WIDTH_DEF;
  localparam int STALL_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [PIX_W-1:0] rg;
    logic [PIX_W-1:0] luma;
    logic             last;
  } overlay_px_t;

  typedef enum int unsigned {CONTENT_NOISE, CONTENT_BINARY, CONTENT_FLAT} content_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [3*PIX_W-1:0]    in_tdata   = '0;                   // red, green, blue
  logic                  in_tuser   = lew_pkg::FUNC_PIXEL;  // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [4*PIX_W-1:0]    out_tdata;                         // red, green, blue, alpha
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor copy of the registers and the block state
  logic [DIM_W-1:0] width_reg  = lew_pkg::FRAME_WIDTH_RST;
  logic [DIM_W-1:0] height_reg = lew_pkg::FRAME_HEIGHT_RST;
  logic [PIX_W-1:0] gain_reg   = lew_pkg::GAIN_RST;
  logic [PIX_W-1:0] thresh_reg = lew_pkg::THRESHOLD_RST;
  logic [PIX_W-1:0] red_above [LINE_DEPTH];
  logic [PIX_W-1:0] red_mid   [LINE_DEPTH];
  logic [PIX_W-1:0] luma_mid  [LINE_DEPTH];
  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] luma_hold;
  int unsigned col_in, row_in, col_out, row_out;

  overlay_px_t expected_pixels [$];

  int          error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stim_count    = 0;
  int          stall_left    = 0;
  bit          stall_request = 1'b0;

  laplacian_edge_overlay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void restart_position();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    return PIX_W'($urandom);
  endfunction

  // gain / threshold value: extremes often, spare upper data bits random
  function automatic logic [CFG_DATA_W-1:0] pick_level();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = lew_pkg::PIX_MAX;
      default: v = rand_pix();
    endcase
    return {(CFG_DATA_W-PIX_W)'($urandom), v};
  endfunction

  // advance the predictor by one accepted item, queue the result it causes
  function automatic void predict_overlay(input logic func, input logic [PIX_W-1:0] r,
                                          input logic [PIX_W-1:0] g,
                                          input logic [PIX_W-1:0] b);
    int unsigned w, h, c, lum, lum_out, sl, se;
    int          lap;
    int          k;
    bit          draining, emit;
    overlay_px_t px;
    w = clamp_dim(width_reg, lew_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, lew_pkg::MAX_HEIGHT_DEF);
    draining = row_in >= h;
    if (func == lew_pkg::FUNC_DRAIN && !draining) return;
    if (func == lew_pkg::FUNC_PIXEL && draining) restart_position();
    if (func == lew_pkg::FUNC_DRAIN) begin
      r = '0;
      g = '0;
      b = '0;
    end
    c = (col_in < LINE_DEPTH) ? col_in : LINE_DEPTH - 1;
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = red_above[c];
    win[5] = red_mid[c];
    win[8] = r;
    red_above[c] = red_mid[c];
    red_mid[c]   = r;

    lum = (lew_pkg::LUMA_COEF_R * r + lew_pkg::LUMA_COEF_G * g
         + lew_pkg::LUMA_COEF_B * b) / 100;
    lum_out     = luma_hold;
    luma_hold   = luma_mid[c];
    luma_mid[c] = PIX_W'(lum);

    emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!emit) return;

    // window column 0/1/2 = x-1/x/x+1, row 0/1/2 = y-1/y/y+1
    lap = 8 * int'(win[4]);
    if (row_out >= 1) begin
      lap -= int'(win[1]);
      if (col_out >= 1) lap -= int'(win[0]);
      if (col_out + 1 < w) lap -= int'(win[2]);
    end
    if (row_out + 1 < h) begin
      lap -= int'(win[7]);
      if (col_out >= 1) lap -= int'(win[6]);
      if (col_out + 1 < w) lap -= int'(win[8]);
    end
    if (col_out >= 1) lap -= int'(win[3]);
    if (col_out + 1 < w) lap -= int'(win[5]);

    sl = lum_out * gain_reg / 255;
    if (sl > 255) sl = 255;
    if (lap <= 0) begin
      se = 0;
    end else begin
      se = lap * gain_reg / 255;
      if (se > 255) se = 255;
    end
    px.luma = PIX_W'(sl);
    px.rg   = (se > thresh_reg && col_out != 0) ? lew_pkg::PIX_MAX : PIX_W'(sl);
    px.last = (col_out + 1 >= w) && (row_out + 1 >= h);
    expected_pixels.push_back(px);

    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (px.last) restart_position();
  endfunction

  task automatic send_item(input logic func, input logic [PIX_W-1:0] r,
                           input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {b, g, r};
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_overlay(func, r, g, b);
  endtask

  task automatic send_drain();
    send_item(lew_pkg::FUNC_DRAIN, rand_pix(), rand_pix(), rand_pix());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      lew_pkg::REG_FRAME_WIDTH: begin
        width_reg = val;
        restart_position();
      end
      lew_pkg::REG_FRAME_HEIGHT: begin
        height_reg = val;
        restart_position();
      end
      lew_pkg::REG_GAIN:      gain_reg   = val[PIX_W-1:0];
      lew_pkg::REG_THRESHOLD: thresh_reg = val[PIX_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every queued result, then let result-less items leave the pipe
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic randomize_setup();
    logic [DIM_W-1:0] w, h;
    settle_block();
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = DIM_W'(1);
      2: w = DIM_W'(2);
      default: w = DIM_W'($urandom_range(3, 12));
    endcase
    case ($urandom_range(0, 7))
      0: h = '0;
      1: h = DIM_W'(1);
      default: h = DIM_W'($urandom_range(2, 6));
    endcase
    write_reg(lew_pkg::REG_FRAME_WIDTH, w);
    write_reg(lew_pkg::REG_FRAME_HEIGHT, h);
    write_reg(lew_pkg::REG_GAIN, pick_level());
    write_reg(lew_pkg::REG_THRESHOLD, pick_level());
  endtask

  // one frame in raster order, then its drain ticks; some frames are broken
  task automatic stream_frame();
    int unsigned w, h, i, n_drain;
    content_t mode;
    logic [PIX_W-1:0] r;
    w = clamp_dim(width_reg, lew_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, lew_pkg::MAX_HEIGHT_DEF);
    mode = content_t'($urandom_range(0, 2));
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_drain();  // stray tick mid-frame
      case (mode)
        CONTENT_NOISE:  r = rand_pix();
        CONTENT_BINARY: r = $urandom_range(0, 1) ? lew_pkg::PIX_MAX : '0;
        default:        r = PIX_W'($urandom_range(100, 140));
      endcase
      send_item(lew_pkg::FUNC_PIXEL, r, rand_pix(), rand_pix());
      stim_count++;
    end
    n_drain = w + 1;
    // short drain: the next pixel cuts the frame off
    if ($urandom_range(0, 7) == 0) n_drain = $urandom_range(0, w);
    repeat (n_drain) begin
      send_drain();
      stim_count++;
    end
    if ($urandom_range(0, 9) == 0) send_drain();
  endtask

  task automatic test_directed_frame();
    int unsigned x, y;
    logic [PIX_W-1:0] r, g, b;
    // gain and threshold stay at their reset values
    write_reg(lew_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(4));
    write_reg(lew_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    // frame not complete: ignored
    send_item(lew_pkg::FUNC_DRAIN, lew_pkg::PIX_MAX, lew_pkg::PIX_MAX, lew_pkg::PIX_MAX);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 4; x++) begin
        r = ((x ^ y) & 1) ? lew_pkg::PIX_MAX : '0;
        g = (x == 3) ? lew_pkg::PIX_MAX : PIX_W'(60 * x);
        b = (y == 2) ? lew_pkg::PIX_MAX : PIX_W'(37 * x);
        send_item(lew_pkg::FUNC_PIXEL, r, g, b);
      end
    end
    repeat (5) send_item(lew_pkg::FUNC_DRAIN, '0, '0, '0);
    settle_block();
  endtask

  task automatic test_single_pixel_frames();
    write_reg(lew_pkg::REG_FRAME_WIDTH, '0);  // zero is taken as one
    write_reg(lew_pkg::REG_FRAME_HEIGHT, '0);
    write_reg(lew_pkg::REG_GAIN, '1);
    write_reg(lew_pkg::REG_THRESHOLD, '0);
    send_item(lew_pkg::FUNC_PIXEL, lew_pkg::PIX_MAX, lew_pkg::PIX_MAX, lew_pkg::PIX_MAX);
    send_drain();  // one-row frame: first tick gives nothing
    send_drain();
    send_item(lew_pkg::FUNC_PIXEL, 8'd200, 8'd10, 8'd90);
    send_drain();
    send_item(lew_pkg::FUNC_PIXEL, 8'd17, 8'd230, 8'd3);  // pixel while draining restarts
    send_drain();
    send_drain();
    send_drain();  // after the last result: ignored
    settle_block();
  endtask

  task automatic test_random_frames(input int unsigned n_items, input int unsigned tx_idle,
                                    input int unsigned rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    stim_count = 0;
    randomize_setup();
    while (stim_count < n_items) begin
      if ($urandom_range(0, 3) == 0) randomize_setup();
      stream_frame();
    end
    settle_block();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle_block();
    write_reg(lew_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(12));
    write_reg(lew_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(4));
    write_reg(lew_pkg::REG_GAIN, CFG_DATA_W'(200));
    write_reg(lew_pkg::REG_THRESHOLD, CFG_DATA_W'(40));
    stall_request = 1'b1;
    repeat (2) stream_frame();
    settle_block();
  endtask

  // widest rows: all-ones values clamp to the maximum, one full row and the start of the next are sent
  task automatic test_full_width_rows();
    int unsigned i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle_block();
    write_reg(lew_pkg::REG_FRAME_WIDTH, '1);
    write_reg(lew_pkg::REG_FRAME_HEIGHT, '1);
    write_reg(lew_pkg::REG_GAIN, pick_level());
    write_reg(lew_pkg::REG_THRESHOLD, pick_level());
    for (i = 0; i < lew_pkg::MAX_WIDTH_DEF + 12; i++)
      send_item(lew_pkg::FUNC_PIXEL, rand_pix(), rand_pix(), rand_pix());
    settle_block();
  endtask

  always @(posedge clk) begin : rx_check
    overlay_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        flag_error("result with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[0 +: PIX_W] !== want.rg)
          flag_error($sformatf("red %0d, want %0d", out_tdata[0 +: PIX_W], want.rg));
        if (out_tdata[PIX_W +: PIX_W] !== want.rg)
          flag_error($sformatf("green %0d, want %0d", out_tdata[PIX_W +: PIX_W], want.rg));
        if (out_tdata[2*PIX_W +: PIX_W] !== want.luma)
          flag_error($sformatf("blue %0d, want %0d", out_tdata[2*PIX_W +: PIX_W],
                               want.luma));
        if (out_tdata[3*PIX_W +: PIX_W] !== lew_pkg::PIX_MAX)
          flag_error($sformatf("alpha %0d, want %0d", out_tdata[3*PIX_W +: PIX_W],
                               lew_pkg::PIX_MAX));
        if (out_tlast !== want.last)
          flag_error($sformatf("frame end %b, want %b", out_tlast, want.last));
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin : rx_ready
    if (stall_request) begin
      stall_left = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : main_seq
    int k;
    for (k = 0; k < LINE_DEPTH; k++) begin
      red_above[k] = '0;
      red_mid[k]   = '0;
      luma_mid[k]  = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;
    luma_hold = '0;
    restart_position();
    send_idle_pct = 19;
    recv_idle_pct = 53;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frame();
    test_single_pixel_frames();
    test_random_frames(100, 19, 53);
    test_random_frames(100, 53, 19);
    test_random_frames(100, 0, 0);
    test_output_stall();
    test_full_width_rows();

    settle_block();
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_pixels.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
